FILE: sv/assert_macros.svh
// Assertion helpers shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge outside reset.
`define CLT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");

// Check that cond never holds outside reset.
`define CLT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define CLT_ASSERT(label, clk, rst_n, prop)
`define CLT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: sv/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

	localparam int RUN_W      = 16;
	localparam int TOK_W      = 8;
	localparam int CONS_W     = 16;
	localparam int KW_COUNT   = 9;
	localparam int KW_MAXLEN  = 6;
	localparam int KW_POS_W   = $clog2(KW_MAXLEN);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	typedef enum logic [3:0] {
		KEY_NONE   = 4'd0,
		KEY_GET    = 4'd1,
		KEY_SET    = 4'd2,
		KEY_DEL    = 4'd3,
		KEY_QUIT   = 4'd4,
		KEY_INFO   = 4'd5,
		KEY_SAVE   = 4'd6,
		KEY_LOAD   = 4'd7,
		KEY_INCR   = 4'd8,
		KEY_SELECT = 4'd9
	} cmd_code_t;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
		'{"G", "E", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL},
		'{"S", "E", "T", CHAR_NUL, CHAR_NUL, CHAR_NUL},
		'{"D", "E", "L", CHAR_NUL, CHAR_NUL, CHAR_NUL},
		'{"Q", "U", "I", "T", CHAR_NUL, CHAR_NUL},
		'{"I", "N", "F", "O", CHAR_NUL, CHAR_NUL},
		'{"S", "A", "V", "E", CHAR_NUL, CHAR_NUL},
		'{"L", "O", "A", "D", CHAR_NUL, CHAR_NUL},
		'{"I", "N", "C", "R", CHAR_NUL, CHAR_NUL},
		'{"S", "E", "L", "E", "C", "T"}
	};

	localparam logic [KW_POS_W-1:0] KW_LEN [KW_COUNT] = '{
		KW_POS_W'(3), KW_POS_W'(3), KW_POS_W'(3), KW_POS_W'(4), KW_POS_W'(4),
		KW_POS_W'(4), KW_POS_W'(4), KW_POS_W'(4), KW_POS_W'(6)
	};

	localparam cmd_code_t KW_CODE [KW_COUNT] = '{
		KEY_GET, KEY_SET, KEY_DEL, KEY_QUIT, KEY_INFO,
		KEY_SAVE, KEY_LOAD, KEY_INCR, KEY_SELECT
	};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} item_t;

	typedef struct packed {
		logic              token_closed;
		logic [TOK_W-1:0]  token_total;
		logic [3:0]        command_code;
		logic              line_complete;
		logic [CONS_W-1:0] bytes_consumed;
		logic              final_result;
	} result_t;

	// Byte after classification, as it waits in the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_delim;
		logic       is_cr;
		logic       is_lf;
		logic       last;
	} class_t;

endpackage

FILE: sv/clt_stream_if.sv
`timescale 1ns / 1ps

interface clt_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/clt_front.sv
`timescale 1ns / 1ps

module clt_front import clt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	clt_stream_if.sink   byte_stream,
	output logic         cls_valid,
	input  logic         cls_ready,
	output class_t       cls_item
);

	logic   valid_s1;
	class_t item_s1;
	class_t item_c;
	logic   take;

	always_comb begin
		item_c.data_byte = byte_stream.payload.data_byte;
		item_c.is_cr     = byte_stream.payload.data_byte == CHAR_CR;
		item_c.is_lf     = byte_stream.payload.data_byte == CHAR_LF;
		item_c.is_delim  = item_c.is_cr || item_c.is_lf ||
			byte_stream.payload.data_byte == CHAR_SPACE;
		item_c.last      = byte_stream.payload.end_of_buffer;
	end

	assign byte_stream.ready = !valid_s1 || cls_ready;
	assign take = byte_stream.valid && byte_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cls_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_c;
		end
	end

	assign cls_valid = valid_s1;
	assign cls_item  = item_s1;

endmodule

FILE: sv/clt_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clt_queue import clt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  class_t push_item,
	output logic   pop_valid,
	input  logic   pop_ready,
	output class_t pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	class_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`CLT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(QUEUE_DEPTH))
	`CLT_ASSERT(a_empty_ptrs, clk, arst_n, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
	`CLT_ASSERT(a_full_ptrs, clk, arst_n, (count_q == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))

endmodule

FILE: sv/clt_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clt_back import clt_pkg::*; #(
	parameter int unsigned     MAX_TOKENS       = 255,
	parameter longint unsigned MAX_BUFFER_BYTES = 65535
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  class_t       item,
	clt_stream_if.source result_stream
);

	localparam logic [TOK_W-1:0] TOK_BOUND =
		(MAX_TOKENS > 255) ? {TOK_W{1'b1}} : TOK_W'(MAX_TOKENS);
	localparam logic [CONS_W-1:0] BYTE_BOUND =
		(MAX_BUFFER_BYTES > 65535) ? {CONS_W{1'b1}} : CONS_W'(MAX_BUFFER_BYTES);
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	logic [RUN_W-1:0]    run_q, run_n, run_inc, run_len;
	logic [TOK_W-1:0]    tok_q, tok_n;
	logic [CONS_W-1:0]   cons_q, cons_n;
	logic [CONS_W+1:0]   cons_sum;
	logic                prev_cr_q;
	logic [KW_COUNT-1:0] cand_q, cand_n, prune;
	cmd_code_t           cmd_q, cmd_n;
	logic                first_done_q, first_n;
	logic                ready_q, ready_n;
	logic                closed;
	logic [KW_POS_W-1:0] pos;
	logic                out_valid_q;
	result_t             out_q, res_c;
	logic                pop;

	assign item_ready = !out_valid_q || result_stream.ready;
	assign pop        = item_valid && item_ready;

	always_comb begin
		ready_n  = ready_q || (prev_cr_q && item.is_lf);
		run_inc  = (run_q == RUN_MAX) ? run_q : run_q + 1'b1;
		pos      = (run_q < RUN_W'(KW_MAXLEN)) ? run_q[KW_POS_W-1:0] : '0;
		cons_sum = {2'b00, cons_q} + {2'b00, run_q} + (CONS_W+2)'(1);
		for (int k = 0; k < KW_COUNT; k++) begin
			prune[k] = (run_q >= RUN_W'(KW_LEN[k])) || (KW_TEXT[k][pos] != item.data_byte);
		end

		if (item.is_delim) begin
			closed  = run_q != '0;
			run_len = run_q;
			run_n   = '0;
			cand_n  = cand_q;
			cons_n  = (cons_sum > (CONS_W+2)'(BYTE_BOUND)) ? BYTE_BOUND : cons_sum[CONS_W-1:0];
		end else begin
			closed  = item.last;
			run_len = run_inc;
			run_n   = run_inc;
			cand_n  = first_done_q ? cand_q : (cand_q & ~prune);
			cons_n  = cons_q;
		end

		tok_n   = tok_q;
		cmd_n   = cmd_q;
		first_n = first_done_q;
		if (closed) begin
			if (tok_q < TOK_BOUND) begin
				tok_n = tok_q + 1'b1;
			end
			if (!first_done_q) begin
				first_n = 1'b1;
				cmd_n   = KEY_NONE;
				// later keywords win, as the list is scanned in order
				for (int k = 0; k < KW_COUNT; k++) begin
					if (cand_n[k] && RUN_W'(KW_LEN[k]) == run_len) begin
						cmd_n = KW_CODE[k];
					end
				end
			end
		end

		res_c.token_closed   = closed;
		res_c.token_total    = tok_n;
		res_c.command_code   = cmd_n;
		res_c.line_complete  = ready_n;
		res_c.bytes_consumed = cons_n;
		res_c.final_result   = item.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			run_q        <= '0;
			tok_q        <= '0;
			cons_q       <= '0;
			prev_cr_q    <= 1'b0;
			cand_q       <= '1;
			cmd_q        <= KEY_NONE;
			first_done_q <= 1'b0;
			ready_q      <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				// drop all buffer state once its last byte is done
				if (item.last) begin
					run_q        <= '0;
					tok_q        <= '0;
					cons_q       <= '0;
					prev_cr_q    <= 1'b0;
					cand_q       <= '1;
					cmd_q        <= KEY_NONE;
					first_done_q <= 1'b0;
					ready_q      <= 1'b0;
				end else begin
					run_q        <= run_n;
					tok_q        <= tok_n;
					cons_q       <= cons_n;
					prev_cr_q    <= item.is_cr;
					cand_q       <= cand_n;
					cmd_q        <= cmd_n;
					first_done_q <= first_n;
					ready_q      <= ready_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_c;
		end
	end

	assign result_stream.valid   = out_valid_q;
	assign result_stream.payload = out_q;

	`CLT_ASSERT(a_tok_bound, clk, arst_n, out_valid_q |-> (out_q.token_total <= TOK_BOUND))
	`CLT_ASSERT(a_closed_counts, clk, arst_n, (out_valid_q && out_q.token_closed) |-> (out_q.token_total != '0))
	`CLT_ASSERT(a_cmd_after_first, clk, arst_n, (cmd_q != KEY_NONE) |-> first_done_q)
	`CLT_ASSERT(a_clear_after_last, clk, arst_n, (pop && item.last) |=> (run_q == '0 && tok_q == '0 && cons_q == '0 && !ready_q))

endmodule

FILE: sv/command_line_tokenizer.sv
`timescale 1ns / 1ps
// Channel        Dir   Payload                                         Handshake
// byte_stream    in    data_byte, end_of_buffer                        valid/ready
// result_stream  out   token_closed, token_total, command_code,        valid/ready
//                      line_complete, bytes_consumed, final_result
//
// One byte per cycle sustained while result_stream stays ready, set by the back end's state update.
// A result is registered in the front register, the queue and the back result
// register in that order, and can transfer out at the next edge once valid.
// arst_n clears all counters, flags and valid bits; no clearing pass is needed.
// Either side may stall: the queue lets the front keep taking bytes while the
// back waits on result_stream, and the result register holds until taken.

module command_line_tokenizer import clt_pkg::*; #(
	parameter int unsigned     MAX_TOKENS       = 255,
	parameter longint unsigned MAX_BUFFER_BYTES = 65535
) (
	input  logic         clk,
	input  logic         arst_n,
	clt_stream_if.sink   byte_stream,
	clt_stream_if.source result_stream
);

	// classified bytes between front and queue
	logic   cls_valid;
	logic   cls_ready;
	class_t cls_item;

	// queue head toward the back end
	logic   head_valid;
	logic   head_ready;
	class_t head_item;

	// Front: take each byte transfer and tag delimiters, CR, LF and buffer end.
	clt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_stream(byte_stream),
		.cls_valid  (cls_valid),
		.cls_ready  (cls_ready),
		.cls_item   (cls_item)
	);

	// Queue: absorb short stalls so front and back advance independently.
	clt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(cls_valid),
		.push_ready(cls_ready),
		.push_item (cls_item),
		.pop_valid (head_valid),
		.pop_ready (head_ready),
		.pop_item  (head_item)
	);

	// Back: update token, byte and keyword state, and register one result per byte.
	clt_back #(
		.MAX_TOKENS      (MAX_TOKENS),
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (head_valid),
		.item_ready   (head_ready),
		.item         (head_item),
		.result_stream(result_stream)
	);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import clt_pkg::*;

	localparam int unsigned     MAX_TOKENS       = 255;
	localparam longint unsigned MAX_BUFFER_BYTES = 65535;

	// Bounds that the token and byte counters hold at.
	localparam logic [TOK_W-1:0]  TOKEN_CAP = (MAX_TOKENS > 255) ? 8'd255 : 8'(MAX_TOKENS);
	localparam logic [CONS_W-1:0] BYTE_CAP  =
		(MAX_BUFFER_BYTES > 65535) ? 16'hFFFF : 16'(MAX_BUFFER_BYTES);

	localparam int RANDOM_ITEMS = 560;
	// Overlong first token ahead of the token count saturation run.
	localparam int LONG_TOKEN   = 40;
	localparam int SAT_TOKENS   = 260;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int IDLE_PCT     = 21;
	// Window of cycles in which neither side idles.
	localparam int QUIET_FROM   = 1000;
	localparam int QUIET_TO     = 1700;
	// Long receiver hold-off, started once this many bytes have been taken.
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;

	// One byte waiting to be sent; wait_empty holds it back until all results are in.
	typedef struct packed {
		item_t byte_item;
		logic  wait_empty;
	} pending_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	clt_stream_if #(.payload_t(item_t))   byte_stream ();
	clt_stream_if #(.payload_t(result_t)) result_stream ();

	command_line_tokenizer #(
		.MAX_TOKENS       (MAX_TOKENS),
		.MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_stream   (byte_stream),
		.result_stream (result_stream)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pending_t byte_backlog [$];
	result_t  due_results [$];
	int       failures    = 0;
	int       cycle       = 0;
	int       bytes_in    = 0;
	logic     byte_taken  = 1'b0;
	int       stall_left  = 0;
	logic     hold_done   = 1'b0;

	// Tokenizer state as the block should hold it.
	logic [TOK_W-1:0]    tok_cnt;
	logic [RUN_W-1:0]    run_len;
	logic [CONS_W-1:0]   used_bytes;
	logic                prev_cr;
	logic [KW_COUNT-1:0] kw_alive;
	cmd_code_t           cmd_seen;
	logic                first_done;
	logic                crlf_seen;

	function automatic void clear_state();
		tok_cnt    = '0;
		run_len    = '0;
		used_bytes = '0;
		prev_cr    = 1'b0;
		kw_alive   = '1;
		cmd_seen   = KEY_NONE;
		first_done = 1'b0;
		crlf_seen  = 1'b0;
	endfunction

	// Count a token; the first one fixes the command from the surviving keywords.
	function automatic void close_token();
		if (tok_cnt < TOKEN_CAP)
			tok_cnt++;
		if (!first_done) begin
			first_done = 1'b1;
			cmd_seen   = KEY_NONE;
			for (int k = 0; k < KW_COUNT; k++)
				if (kw_alive[k] && RUN_W'(KW_LEN[k]) == run_len)
					cmd_seen = KW_CODE[k];
		end
	endfunction

	// Advance the tokenizer by one byte and return the result it shows.
	function automatic result_t tokenize_byte(input item_t it);
		result_t          r;
		logic             delim;
		logic             closed;
		logic [CONS_W:0]  sum;
		int               pos;
		delim  = it.data_byte inside {CHAR_SPACE, CHAR_CR, CHAR_LF};
		closed = 1'b0;
		if (prev_cr && it.data_byte == CHAR_LF)
			crlf_seen = 1'b1;
		if (delim) begin
			if (run_len != 0) begin
				closed = 1'b1;
				close_token();
			end
			sum        = {1'b0, used_bytes} + {1'b0, run_len} + 1'b1;
			used_bytes = (sum > BYTE_CAP) ? BYTE_CAP : sum[CONS_W-1:0];
			run_len    = '0;
		end else begin
			// Drop every keyword that this byte rules out.
			if (!first_done) begin
				pos = (run_len < KW_MAXLEN) ? int'(run_len) : 0;
				for (int k = 0; k < KW_COUNT; k++)
					if (run_len >= RUN_W'(KW_LEN[k]) || KW_TEXT[k][pos] != it.data_byte)
						kw_alive[k] = 1'b0;
			end
			if (run_len != '1)
				run_len++;
			// A run still open at the buffer end counts as a token.
			if (it.end_of_buffer) begin
				closed = 1'b1;
				close_token();
			end
		end
		prev_cr = (it.data_byte == CHAR_CR);

		r.token_closed   = closed;
		r.token_total    = tok_cnt;
		r.command_code   = cmd_seen;
		r.line_complete  = crlf_seen;
		r.bytes_consumed = used_bytes;
		r.final_result   = it.end_of_buffer;
		if (it.end_of_buffer)
			clear_state();
		return r;
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic last);
		pending_t p;
		p.byte_item.data_byte     = b;
		p.byte_item.end_of_buffer = last;
		p.wait_empty              = 1'b0;
		byte_backlog.push_back(p);
	endfunction

	function automatic void push_text(input string s, input logic end_last);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], end_last && i == s.len() - 1);
	endfunction

	// Send a whole buffer, flagging its final byte as the last.
	function automatic void push_line(input logic [7:0] line [$]);
		for (int i = 0; i < line.size(); i++)
			push_byte(line[i], i == line.size() - 1);
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b inside {CHAR_SPACE, CHAR_CR, CHAR_LF});
		return b;
	endfunction

	function automatic logic [7:0] delim_byte();
		case ($urandom_range(2))
			0: return CHAR_SPACE;
			1: return CHAR_CR;
			default: return CHAR_LF;
		endcase
	endfunction

	// Keyword (sometimes mangled), up to four arguments, a CR LF terminator half the time.
	function automatic void push_command();
		logic [7:0] line [$];
		int         k;
		k = $urandom_range(KW_COUNT - 1);
		if ($urandom_range(9) == 0)
			line.push_back(CHAR_SPACE);
		for (int i = 0; i < KW_LEN[k]; i++)
			line.push_back(KW_TEXT[k][i]);
		case ($urandom_range(9))
			0: void'(line.pop_back());
			1: line.push_back(word_byte());
			2: line[line.size() - 1] = line[line.size() - 1] ^ 8'h20;
			default: ;
		endcase
		repeat ($urandom_range(4)) begin
			repeat ($urandom_range(1, 2))
				line.push_back(CHAR_SPACE);
			repeat ($urandom_range(1, 8))
				line.push_back(word_byte());
		end
		case ($urandom_range(3))
			0, 1: begin
				line.push_back(CHAR_CR);
				line.push_back(CHAR_LF);
			end
			2: line.push_back(CHAR_LF);
			default: ;
		endcase
		push_line(line);
	endfunction

	// Broken framing: heavy on CR, LF and keyword letters, or raw noise.
	function automatic void push_scramble(input logic framing);
		logic [7:0] line [$];
		logic [7:0] pick [7];
		pick = '{CHAR_CR, CHAR_LF, CHAR_SPACE, "S", "E", "T", "L"};
		repeat ($urandom_range(1, 20)) begin
			if (framing)
				line.push_back(pick[$urandom_range(6)]);
			else if ($urandom_range(3) == 0)
				line.push_back(delim_byte());
			else
				line.push_back(8'($urandom_range(255)));
		end
		push_line(line);
	endfunction

	// Idle at random, except inside the quiet window.
	function automatic logic take_break();
		return (cycle < QUIET_FROM || cycle >= QUIET_TO) && ($urandom_range(99) < IDLE_PCT);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	// Driver: present the head of the backlog, hold it until the transfer.
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_stream.valid <= 1'b0;
		end else begin
			if (byte_taken)
				void'(byte_backlog.pop_front());
			if (!byte_stream.valid || byte_taken) begin
				if (byte_backlog.size() != 0 && !take_break() &&
						!(byte_backlog[0].wait_empty && due_results.size() != 0)) begin
					byte_stream.valid   <= 1'b1;
					byte_stream.payload <= byte_backlog[0].byte_item;
				end else begin
					byte_stream.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random ready, plus one long hold-off to back the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stream.ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_stream.ready <= 1'b0;
			stall_left          <= stall_left - 1;
		end else if (!hold_done && bytes_in >= HOLD_AT) begin
			result_stream.ready <= 1'b0;
			stall_left          <= HOLD_CYCLES;
			hold_done           <= 1'b1;
		end else begin
			result_stream.ready <= !take_break();
		end
	end

	// Monitor: check each result transfer, then predict for each byte transfer.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		byte_taken = arst_n && byte_stream.valid && byte_stream.ready;
		if (arst_n && result_stream.valid && result_stream.ready) begin
			seen = result_stream.payload;
			if (due_results.size() == 0) begin
				$error("result transfer with nothing outstanding");
				failures++;
			end else begin
				want = due_results.pop_front();
				check_field("token_closed", want.token_closed, seen.token_closed);
				check_field("token_total", want.token_total, seen.token_total);
				check_field("command_code", want.command_code, seen.command_code);
				check_field("line_complete", want.line_complete, seen.line_complete);
				check_field("bytes_consumed", want.bytes_consumed, seen.bytes_consumed);
				check_field("final_result", want.final_result, seen.final_result);
			end
		end
		if (byte_taken) begin
			due_results.push_back(tokenize_byte(byte_stream.payload));
			bytes_in++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle++;
		if (cycle > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int start;
		byte_stream.valid   = 1'b0;
		byte_stream.payload = '0;
		result_stream.ready = 1'b0;
		clear_state();

		// Directed: a plain command line with CR LF.
		push_text("GET", 1'b0);
		push_byte(CHAR_CR, 1'b0);
		push_byte(CHAR_LF, 1'b1);
		// Zero byte inside a token, and a token left open at the buffer end.
		push_byte(CHAR_NUL, 1'b0);
		push_byte(8'hFF, 1'b1);
		// CR closes one buffer; the LF that opens the next must not pair with it.
		push_text("SET", 1'b0);
		push_byte(CHAR_CR, 1'b1);
		push_byte(CHAR_LF, 1'b1);
		// Overlong first token matches nothing.
		push_text("SELECTS", 1'b1);
		// Delimiters only: no token at all.
		push_byte(CHAR_SPACE, 1'b0);
		push_byte(CHAR_SPACE, 1'b1);
		push_text("SELECT", 1'b1);

		// Random: mostly well-formed lines, the rest broken framing and noise.
		start = byte_backlog.size();
		while (byte_backlog.size() - start < RANDOM_ITEMS) begin
			case ($urandom_range(99)) inside
				[0:69]:  push_command();
				[70:84]: push_scramble(1'b1);
				default: push_scramble(1'b0);
			endcase
		end
		byte_backlog[start].wait_empty = 1'b1;

		// Saturation: an overlong first token, then enough short tokens to pin the count.
		start = byte_backlog.size();
		repeat (LONG_TOKEN)
			push_byte(word_byte(), 1'b0);
		byte_backlog[start].wait_empty = 1'b1;
		repeat (SAT_TOKENS) begin
			push_byte(CHAR_SPACE, 1'b0);
			push_byte(word_byte(), 1'b0);
		end
		push_byte(CHAR_CR, 1'b0);
		push_byte(CHAR_LF, 1'b1);

		repeat (8) @(posedge clk);
		#1 arst_n = 1'b1;

		// Drain, then watch for any stray result before reporting.
		while (byte_backlog.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
